// ===== rtl/rmb_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, codes and the reciprocal table of the Romberg integrator.
// No dependencies; used by romberg_integrator.
package rmb_pkg;

    localparam int DEFAULT_MAX_LEVELS = 30;
    localparam int DATA_BITS          = 32;
    localparam int ACC_BITS           = 48;
    localparam int PROD_BITS          = 80;
    localparam int CFG_ADDR_BITS      = 3;
    localparam int CFG_DATA_BITS      = 32;

    localparam logic [2:0] REG_LOWER   = 3'd0;
    localparam logic [2:0] REG_UPPER   = 3'd1;
    localparam logic [2:0] REG_TOL     = 3'd2;
    localparam logic [2:0] REG_MIN_INT = 3'd3;
    localparam logic [2:0] REG_MAX_INT = 3'd4;

    localparam logic [1:0] KIND_SAMPLE = 2'd0;
    localparam logic [1:0] KIND_RESULT = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    localparam logic signed [31:0] RST_LOWER   = 32'sd0;
    localparam logic signed [31:0] RST_UPPER   = 32'sd65536;
    localparam logic [30:0]        RST_TOL     = 31'd1;
    localparam logic [30:0]        RST_MIN_INT = 31'd50;
    localparam logic [30:0]        RST_MAX_INT = 31'd1000000;

    localparam logic signed [47:0] MAX48 = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] MIN48 = 48'sh8000_0000_0000;

    localparam logic [5:0] SH_PREV = 6'd17;
    localparam logic [5:0] SH_ROW  = 6'd18;
    localparam logic [5:0] SH_CORR = 6'd32;

    // round(2^32 / (4^m - 1)) in Q0.32
    function automatic logic [31:0] recip(input logic [5:0] m);
        logic [31:0] r;
        case (m)
            6'd1:    r = 32'd1431655765;
            6'd2:    r = 32'd286331153;
            6'd3:    r = 32'd68174084;
            6'd4:    r = 32'd16843009;
            6'd5:    r = 32'd4198404;
            6'd6:    r = 32'd1048832;
            6'd7:    r = 32'd262160;
            6'd8:    r = 32'd65537;
            6'd9:    r = 32'd16384;
            6'd10:   r = 32'd4096;
            6'd11:   r = 32'd1024;
            6'd12:   r = 32'd256;
            6'd13:   r = 32'd64;
            6'd14:   r = 32'd16;
            6'd15:   r = 32'd4;
            6'd16:   r = 32'd1;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [48:0] v);
        logic signed [47:0] r;
        if (v[48] != v[47]) begin
            r = v[48] ? MIN48 : MAX48;
        end else begin
            r = v[47:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/rmb_ram.sv =====
`timescale 1ns / 1ps
// Generic single-port RAM with registered read data.
// No dependencies.
module rmb_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 30
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/romberg_integrator.sv =====
`timescale 1ns / 1ps
// Romberg integrator top level: sequencer, shared multiplier and output register.
// Depends on rmb_pkg and rmb_ram.
//
// Usage: configure bounds, tolerance and interval limits through the write
// port while idle. Send a beat with i_restart high to start a run; every
// result beat of kind sample asks for f at o_abscissa, answered by an input
// beat with i_restart low carrying i_sample_value. The run ends with a beat of
// kind result (integral and converged flag) or kind error (max below min).
// Each input beat yields at most one result beat; a sample beat while idle is
// dropped. Restarts, the first end sample and within-level samples answer in the
// cycle after acceptance. The second end sample goes through one shared 32x32
// multiplier in two passes plus a shift/clamp and a write-back step, then a
// next-level step that answers once the output register is free. A level end
// takes the same steps through the write-back, then walks the Richardson row
// entry by entry (RAM read, difference, two multiply passes, shift/clamp,
// write-back), then a check and a next-level step; a converged run answers from
// the check. The block accepts no beat meanwhile.
// Reset (synchronous, active low) returns to idle with registers at defaults.
// A stalled receiver holds the result register; intake waits until it drains.
module romberg_integrator #(
    parameter int MAX_LEVELS = rmb_pkg::DEFAULT_MAX_LEVELS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [rmb_pkg::CFG_ADDR_BITS-1:0] i_cfg_addr,
    input  logic [rmb_pkg::CFG_DATA_BITS-1:0] i_cfg_wdata,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_restart,
    input  logic signed [31:0]                i_sample_value,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [1:0]                        o_result_kind,
    output logic signed [31:0]                o_abscissa,
    output logic signed [47:0]                o_integral,
    output logic                              o_converged
);

    localparam int LW = $clog2(MAX_LEVELS + 1);
    localparam int RW = $clog2(MAX_LEVELS);
    localparam int PW = MAX_LEVELS;
    localparam int AW = 32 + MAX_LEVELS;
    localparam int PROD_W = rmb_pkg::PROD_BITS;

    typedef enum logic [8:0] {
        S_WAIT  = 9'b000000001,
        S_MUL0  = 9'b000000010,
        S_MUL1  = 9'b000000100,
        S_SHIFT = 9'b000001000,
        S_USE   = 9'b000010000,
        S_RD    = 9'b000100000,
        S_DIFF  = 9'b001000000,
        S_CHECK = 9'b010000000,
        S_BEGIN = 9'b100000000
    } t_state;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_A    = 2'd1,
        PH_B    = 2'd2,
        PH_MID  = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        D_PREV = 2'd0,
        D_ROW  = 2'd1,
        D_CORR = 2'd2
    } t_dest;

    logic signed [31:0] r_lower, n_lower, r_upper, n_upper;
    logic [30:0]        r_tol, n_tol, r_min, n_min, r_max, n_max;

    t_state             r_state, n_state;
    t_phase             r_phase, n_phase;
    t_dest              r_dest, n_dest;
    logic signed [47:0] r_sum, n_sum, r_prev, n_prev, r_cur, n_cur, r_scaled, n_scaled;
    logic [LW-1:0]      r_level, n_level, r_k, n_k;
    logic [31:0]        r_icount, n_icount;
    logic [PW-1:0]      r_point, n_point;
    logic               r_swap, n_swap;
    logic [31:0]        r_step, n_step;
    logic signed [31:0] r_start, n_start;
    logic [AW-1:0]      r_acc, n_acc;
    logic [47:0]        r_mag, n_mag;
    logic               r_neg, n_neg;
    logic [31:0]        r_mul, n_mul;
    logic [5:0]         r_sh, n_sh;
    logic [PROD_W-1:0]  r_prod, n_prod;

    logic               r_out_valid, n_out_valid;
    logic [1:0]         r_out_kind, n_out_kind;
    logic signed [31:0] r_out_absc, n_out_absc;
    logic signed [47:0] r_out_integ, n_out_integ;
    logic               r_out_conv, n_out_conv;

    logic               w_slot, w_accept;
    logic [31:0]        w_mul_a;
    logic [63:0]        w_product;
    logic [AW-1:0]      w_mid_src;
    logic signed [31:0] w_mid;
    logic               w_ram_we;
    logic [RW-1:0]      w_ram_addr;
    logic signed [47:0] w_ram_wdata, w_ram_rdata;

    rmb_ram #(
        .WIDTH (rmb_pkg::ACC_BITS),
        .DEPTH (MAX_LEVELS)
    ) u_row (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_addr  (w_ram_addr),
        .i_wdata (w_ram_wdata),
        .o_rdata (w_ram_rdata)
    );

    assign w_slot     = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_WAIT) && w_slot;
    assign w_accept   = i_in_valid && o_in_ready;

    assign w_mul_a   = (r_state == S_MUL0) ? r_mag[31:0] : {16'd0, r_mag[47:32]};
    assign w_product = 64'(w_mul_a) * 64'(r_mul);

    assign w_mid_src = (r_state == S_BEGIN) ? AW'(r_step)
                                            : r_acc + (AW'(r_step) << 1);
    assign w_mid     = r_start + 32'(w_mid_src >> (6'(r_level) + 6'd1));

    always_comb begin
        logic signed [48:0] v_add;
        logic signed [47:0] v_new;
        logic signed [48:0] v_diff;
        logic [48:0]        v_abs;
        logic [PROD_W-1:0]  v_shift;
        logic [47:0]        v_clamp;
        logic signed [31:0] v_lo, v_hi;
        logic               v_last;

        n_lower = r_lower; n_upper = r_upper; n_tol = r_tol;
        n_min = r_min; n_max = r_max;
        n_state = r_state; n_phase = r_phase; n_dest = r_dest;
        n_sum = r_sum; n_prev = r_prev; n_cur = r_cur; n_scaled = r_scaled;
        n_level = r_level; n_k = r_k; n_icount = r_icount; n_point = r_point;
        n_swap = r_swap; n_step = r_step; n_start = r_start; n_acc = r_acc;
        n_mag = r_mag; n_neg = r_neg; n_mul = r_mul; n_sh = r_sh; n_prod = r_prod;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_kind = r_out_kind; n_out_absc = r_out_absc;
        n_out_integ = r_out_integ; n_out_conv = r_out_conv;
        w_ram_we = 1'b0;
        w_ram_addr = RW'(r_k - LW'(1));
        w_ram_wdata = r_scaled;
        v_add = '0; v_new = '0; v_diff = '0; v_abs = '0; v_shift = '0; v_clamp = '0;
        v_lo = r_lower; v_hi = r_upper;
        v_last = (r_point == ~(~PW'(0) << r_level));

        if (i_cfg_we) begin
            case (i_cfg_addr)
                rmb_pkg::REG_LOWER:   n_lower = i_cfg_wdata;
                rmb_pkg::REG_UPPER:   n_upper = i_cfg_wdata;
                rmb_pkg::REG_TOL:     n_tol = i_cfg_wdata[30:0];
                rmb_pkg::REG_MIN_INT: n_min = i_cfg_wdata[30:0];
                rmb_pkg::REG_MAX_INT: n_max = i_cfg_wdata[30:0];
                default: ;
            endcase
        end

        case (r_state)
            S_WAIT: begin
                if (w_accept) begin
                    if (i_restart) begin
                        if (r_max < r_min) begin
                            n_phase = PH_IDLE;
                            n_out_valid = 1'b1;
                            n_out_kind = rmb_pkg::KIND_ERROR;
                            n_out_absc = '0; n_out_integ = '0; n_out_conv = 1'b0;
                        end else begin
                            n_swap = r_lower > r_upper;
                            if (r_lower > r_upper) begin
                                v_lo = r_upper; v_hi = r_lower;
                            end
                            n_start = v_lo;
                            n_step = v_hi - v_lo;
                            n_sum = '0; n_prev = '0; n_level = '0;
                            n_icount = 32'd2; n_point = '0;
                            n_phase = PH_A;
                            n_out_valid = 1'b1;
                            n_out_kind = rmb_pkg::KIND_SAMPLE;
                            n_out_absc = v_lo; n_out_integ = '0; n_out_conv = 1'b0;
                        end
                    end else begin
                        case (r_phase)
                            PH_A: begin
                                n_sum = 48'(i_sample_value);
                                n_phase = PH_B;
                                n_out_valid = 1'b1;
                                n_out_kind = rmb_pkg::KIND_SAMPLE;
                                n_out_absc = r_start + r_step;
                                n_out_integ = '0; n_out_conv = 1'b0;
                            end
                            PH_B: begin
                                v_add = 49'(r_sum) + 49'(i_sample_value);
                                v_new = rmb_pkg::sat48(v_add);
                                n_sum = v_new;
                                n_neg = v_new[47];
                                n_mag = v_new[47] ? 48'(-v_new) : 48'(v_new);
                                n_mul = r_step; n_sh = rmb_pkg::SH_PREV; n_dest = D_PREV;
                                n_state = S_MUL0;
                            end
                            PH_MID: begin
                                v_add = 49'(r_sum) + (49'(i_sample_value) <<< 1);
                                v_new = rmb_pkg::sat48(v_add);
                                n_sum = v_new;
                                n_point = r_point + PW'(1);
                                if (v_last) begin
                                    n_neg = v_new[47];
                                    n_mag = v_new[47] ? 48'(-v_new) : 48'(v_new);
                                    n_mul = r_step;
                                    n_sh = rmb_pkg::SH_ROW + 6'(r_level);
                                    n_dest = D_ROW;
                                    n_state = S_MUL0;
                                end else begin
                                    n_acc = w_mid_src;
                                    n_out_valid = 1'b1;
                                    n_out_kind = rmb_pkg::KIND_SAMPLE;
                                    n_out_absc = w_mid;
                                    n_out_integ = '0; n_out_conv = 1'b0;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
            end
            S_MUL0: begin
                n_prod = PROD_W'(w_product);
                n_state = S_MUL1;
            end
            S_MUL1: begin
                n_prod = r_prod + (PROD_W'(w_product) << 32);
                n_state = S_SHIFT;
            end
            S_SHIFT: begin
                v_shift = r_prod >> r_sh;
                if (v_shift > PROD_W'(rmb_pkg::MAX48)) begin
                    v_clamp = 48'(rmb_pkg::MAX48);
                end else begin
                    v_clamp = v_shift[47:0];
                end
                n_scaled = r_neg ? 48'(-v_clamp) : 48'(v_clamp);
                n_state = S_USE;
            end
            S_USE: begin
                case (r_dest)
                    D_PREV: begin
                        n_prev = r_scaled;
                        n_state = S_BEGIN;
                    end
                    D_ROW: begin
                        w_ram_we = 1'b1;
                        w_ram_addr = RW'(r_level);
                        w_ram_wdata = r_scaled;
                        n_cur = r_scaled;
                        n_k = r_level;
                        n_state = (r_level == '0) ? S_CHECK : S_RD;
                    end
                    default: begin
                        v_add = 49'(r_cur) + 49'(r_scaled);
                        v_new = rmb_pkg::sat48(v_add);
                        w_ram_we = 1'b1;
                        w_ram_wdata = v_new;
                        n_cur = v_new;
                        n_k = r_k - LW'(1);
                        n_state = (r_k == LW'(1)) ? S_CHECK : S_RD;
                    end
                endcase
            end
            S_RD: begin
                n_state = S_DIFF;
            end
            S_DIFF: begin
                v_diff = 49'(r_cur) - 49'(w_ram_rdata);
                n_neg = v_diff[48];
                v_abs = v_diff[48] ? 49'(-v_diff) : 49'(v_diff);
                n_mag = v_abs[47:0];
                n_mul = rmb_pkg::recip(6'(r_level) - 6'(r_k) + 6'd1);
                n_sh = rmb_pkg::SH_CORR;
                n_dest = D_CORR;
                n_state = S_MUL0;
            end
            S_CHECK: begin
                v_diff = 49'(r_cur) - 49'(r_prev);
                v_abs = v_diff[48] ? 49'(-v_diff) : 49'(v_diff);
                if (r_icount >= {1'b0, r_min} && v_abs <= 49'(r_tol)) begin
                    if (w_slot) begin
                        n_phase = PH_IDLE;
                        n_out_valid = 1'b1;
                        n_out_kind = rmb_pkg::KIND_RESULT;
                        n_out_absc = '0;
                        n_out_integ = r_swap ? 48'(-r_cur) : r_cur;
                        n_out_conv = 1'b1;
                        n_state = S_WAIT;
                    end
                end else begin
                    n_prev = r_cur;
                    n_level = r_level + LW'(1);
                    n_icount = r_icount << 1;
                    n_state = S_BEGIN;
                end
            end
            S_BEGIN: begin
                if (w_slot) begin
                    n_out_valid = 1'b1;
                    if (32'(r_level) < 32'(MAX_LEVELS) && r_icount < {1'b0, r_max}) begin
                        n_point = '0;
                        n_acc = w_mid_src;
                        n_phase = PH_MID;
                        n_out_kind = rmb_pkg::KIND_SAMPLE;
                        n_out_absc = w_mid;
                        n_out_integ = '0; n_out_conv = 1'b0;
                    end else begin
                        n_phase = PH_IDLE;
                        n_out_kind = rmb_pkg::KIND_RESULT;
                        n_out_absc = '0;
                        n_out_integ = r_swap ? 48'(-r_prev) : r_prev;
                        n_out_conv = 1'b0;
                    end
                    n_state = S_WAIT;
                end
            end
            default: n_state = S_WAIT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lower <= rmb_pkg::RST_LOWER;
            r_upper <= rmb_pkg::RST_UPPER;
            r_tol <= rmb_pkg::RST_TOL;
            r_min <= rmb_pkg::RST_MIN_INT;
            r_max <= rmb_pkg::RST_MAX_INT;
            r_state <= S_WAIT;
            r_phase <= PH_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_lower <= n_lower;
            r_upper <= n_upper;
            r_tol <= n_tol;
            r_min <= n_min;
            r_max <= n_max;
            r_state <= n_state;
            r_phase <= n_phase;
            r_out_valid <= n_out_valid;
        end
        r_dest <= n_dest;
        r_sum <= n_sum;
        r_prev <= n_prev;
        r_cur <= n_cur;
        r_scaled <= n_scaled;
        r_level <= n_level;
        r_k <= n_k;
        r_icount <= n_icount;
        r_point <= n_point;
        r_swap <= n_swap;
        r_step <= n_step;
        r_start <= n_start;
        r_acc <= n_acc;
        r_mag <= n_mag;
        r_neg <= n_neg;
        r_mul <= n_mul;
        r_sh <= n_sh;
        r_prod <= n_prod;
        r_out_kind <= n_out_kind;
        r_out_absc <= n_out_absc;
        r_out_integ <= n_out_integ;
        r_out_conv <= n_out_conv;
    end

    assign o_out_valid   = r_out_valid;
    assign o_result_kind = r_out_kind;
    assign o_abscissa    = r_out_absc;
    assign o_integral    = r_out_integ;
    assign o_converged   = r_out_conv;

    a_mul_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL0) |=> (r_state == S_MUL1))
        else $error("multiplier passes out of order");

    a_sample_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_result_kind == rmb_pkg::KIND_SAMPLE) |-> (r_phase != PH_IDLE))
        else $error("sample request while idle");

    a_walk_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK) |-> (r_k == '0))
        else $error("convergence check before row walk ended");

    a_no_intake_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_USE || r_state == S_DIFF) |-> !o_in_ready)
        else $error("intake open during row update");

endmodule

// ===== test/tb_romberg_integrator.sv =====
`timescale 1ns / 1ps
// Self-checking bench for romberg_integrator: drives integration runs of random
// samples, predicts every result beat in a built-in Q16.16 model and compares.
// Depends on rmb_pkg and the romberg_integrator RTL.
module tb_romberg_integrator;

    localparam int  SETTLE_CYCLES = 300;
    localparam int  LIMIT_CYCLES  = 3000000;
    localparam int  ROW_DEPTH     = 30;
    localparam longint SAT_HI     = 64'sh7FFF_FFFF_FFFF;
    localparam longint SAT_LO     = -SAT_HI - 1;

    typedef enum logic [1:0] {PH_IDLE, PH_WANT_A, PH_WANT_B, PH_WANT_MID} t_phase;

    typedef struct {
        logic [1:0]         kind;
        logic signed [31:0] absc;
        logic signed [47:0] integ;
        logic               conv;
    } t_beat;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [2:0]         i_cfg_addr;
    logic [31:0]        i_cfg_wdata;
    logic               i_in_valid;
    logic               o_in_ready;
    logic               i_restart;
    logic signed [31:0] i_sample_value;
    logic               o_out_valid;
    logic               i_out_ready;
    logic [1:0]         o_result_kind;
    logic signed [31:0] o_abscissa;
    logic signed [47:0] o_integral;
    logic               o_converged;

    romberg_integrator u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_restart      (i_restart),
        .i_sample_value (i_sample_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_result_kind  (o_result_kind),
        .o_abscissa     (o_abscissa),
        .o_integral     (o_integral),
        .o_converged    (o_converged)
    );

    // model state
    logic signed [31:0] cfg_lower, cfg_upper;
    logic [30:0]        cfg_tol, cfg_min_int, cfg_max_int;
    longint             row [ROW_DEPTH];
    longint             run_sum, prev_est, run_start;
    int unsigned        level;
    longint unsigned    n_intervals, point;
    t_phase             phase;
    bit                 swapped;
    logic [31:0]        span;

    t_beat  expected_beats[$];
    int     error_count;
    int     items_sent;
    int     in_idle_pct;
    int     out_idle_pct;
    longint cycles;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= out_idle_pct);
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        t_beat e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_beats.size() == 0) begin
                report_mismatch($sformatf("unexpected beat kind %0d", o_result_kind));
            end else begin
                e = expected_beats.pop_front();
                if (o_result_kind !== e.kind)
                    report_mismatch($sformatf("kind %0d want %0d", o_result_kind, e.kind));
                if (o_abscissa !== e.absc)
                    report_mismatch($sformatf("abscissa %h want %h", o_abscissa, e.absc));
                if (o_integral !== e.integ)
                    report_mismatch($sformatf("integral %h want %h", o_integral, e.integ));
                if (o_converged !== e.conv)
                    report_mismatch($sformatf("converged %b want %b", o_converged, e.conv));
            end
        end
    end

    function automatic longint clamp48(input longint v);
        return (v > SAT_HI) ? SAT_HI : ((v < SAT_LO) ? SAT_LO : v);
    endfunction

    // (|v| * mul) >> sh, clamped symmetrically, sign restored
    function automatic longint scale_mag(input logic [31:0] mul, input longint v, input int sh);
        longint unsigned mag;
        logic [95:0]     p;
        longint          r;
        mag = (v < 0) ? -v : v;
        p = (96'(mag) * 96'(mul)) >> sh;
        r = (p > 96'(SAT_HI)) ? SAT_HI : longint'(p[63:0]);
        return (v < 0) ? -r : r;
    endfunction

    function automatic logic [31:0] richardson_weight(input int unsigned m);
        longint unsigned den;
        den = (64'd1 << (2 * m)) - 1;
        return 32'((((64'd1 << 33) / den) + 1) >> 1);
    endfunction

    function automatic longint next_abscissa();
        longint unsigned off;
        off = (64'(span) * (2 * point + 1)) >> (level + 1);
        return run_start + longint'(off);
    endfunction

    function automatic t_beat make_beat(input logic [1:0] k, input longint a,
                                        input longint v, input bit c);
        t_beat b;
        b.kind  = k;
        b.absc  = a[31:0];
        b.integ = v[47:0];
        b.conv  = c;
        return b;
    endfunction

    function automatic t_beat close_run(input longint v, input bit c);
        phase = PH_IDLE;
        return make_beat(rmb_pkg::KIND_RESULT, 0, swapped ? -v : v, c);
    endfunction

    function automatic t_beat open_level();
        if (level < ROW_DEPTH && n_intervals < 64'(cfg_max_int)) begin
            point = 0;
            phase = PH_WANT_MID;
            return make_beat(rmb_pkg::KIND_SAMPLE, next_abscissa(), 0, 1'b0);
        end
        return close_run(prev_est, 1'b0);
    endfunction

    function automatic bit integrate_beat(input bit restart, input logic signed [31:0] f,
                                          output t_beat b);
        longint lo, hi, t, d;
        if (restart) begin
            if (cfg_max_int < cfg_min_int) begin
                phase = PH_IDLE;
                b = make_beat(rmb_pkg::KIND_ERROR, 0, 0, 1'b0);
                return 1'b1;
            end
            lo = cfg_lower;
            hi = cfg_upper;
            swapped = lo > hi;
            if (swapped) begin
                t = lo;
                lo = hi;
                hi = t;
            end
            run_start = lo;
            span = 32'(hi - lo);
            run_sum = 0;
            prev_est = 0;
            level = 0;
            n_intervals = 2;
            point = 0;
            phase = PH_WANT_A;
            b = make_beat(rmb_pkg::KIND_SAMPLE, lo, 0, 1'b0);
            return 1'b1;
        end
        case (phase)
            PH_WANT_A: begin
                run_sum = f;
                phase = PH_WANT_B;
                b = make_beat(rmb_pkg::KIND_SAMPLE, run_start + longint'(span), 0, 1'b0);
            end
            PH_WANT_B: begin
                run_sum = clamp48(run_sum + f);
                prev_est = scale_mag(span, run_sum, rmb_pkg::SH_PREV);
                b = open_level();
            end
            PH_WANT_MID: begin
                run_sum = clamp48(run_sum + clamp48(2 * longint'(f)));
                point++;
                if (point < (64'd1 << level)) begin
                    b = make_beat(rmb_pkg::KIND_SAMPLE, next_abscissa(), 0, 1'b0);
                    return 1'b1;
                end
                row[level] = scale_mag(span, run_sum, level + rmb_pkg::SH_ROW);
                for (int k = level; k > 0; k--) begin
                    d = row[k] - row[k-1];
                    row[k-1] = clamp48(row[k] +
                        scale_mag(richardson_weight(level - k + 1), d, rmb_pkg::SH_CORR));
                end
                d = row[0] - prev_est;
                if (d < 0) d = -d;
                if (n_intervals >= 64'(cfg_min_int) && d <= longint'(cfg_tol)) begin
                    b = close_run(row[0], 1'b1);
                    return 1'b1;
                end
                prev_est = row[0];
                level++;
                n_intervals <<= 1;
                b = open_level();
            end
            default: return 1'b0;
        endcase
        return 1'b1;
    endfunction

    task automatic send_beat(input bit restart, input logic signed [31:0] f);
        t_beat b;
        if ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_restart      <= restart;
        i_sample_value <= f;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
        if (integrate_beat(restart, f, b)) expected_beats.push_back(b);
    endtask

    task automatic drain_and_settle();
        i_in_valid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        case (idx)
            rmb_pkg::REG_LOWER:   cfg_lower   = val;
            rmb_pkg::REG_UPPER:   cfg_upper   = val;
            rmb_pkg::REG_TOL:     cfg_tol     = val[30:0];
            rmb_pkg::REG_MIN_INT: cfg_min_int = val[30:0];
            rmb_pkg::REG_MAX_INT: cfg_max_int = val[30:0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic [31:0] lo, input logic [31:0] hi, input logic [31:0] tol,
                             input logic [31:0] mn, input logic [31:0] mx);
        drain_and_settle();
        write_reg(rmb_pkg::REG_LOWER, lo);
        write_reg(rmb_pkg::REG_UPPER, hi);
        write_reg(rmb_pkg::REG_TOL, tol);
        write_reg(rmb_pkg::REG_MIN_INT, mn);
        write_reg(rmb_pkg::REG_MAX_INT, mx);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] pick_sample(input int mode);
        case (mode)
            1:       return 32'd0;
            2:       return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: begin
                case ($urandom_range(3))
                    0:       return $urandom;
                    1:       return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
                    default: return 32'($signed($urandom_range(0, 2 ** 20)) - 2 ** 19);
                endcase
            end
        endcase
    endfunction

    // restart, then answer every request; optionally break the sequence
    task automatic run_sequence(input int mode, input bit allow_break);
        send_beat(1'b1, $urandom);
        while (phase != PH_IDLE) begin
            if (allow_break && $urandom_range(59) == 0)
                send_beat(1'b1, $urandom);
            else
                send_beat(1'b0, pick_sample(mode));
        end
        if (allow_break && $urandom_range(7) == 0) send_beat(1'b0, $urandom);
    endtask

    task automatic test_directed();
        in_idle_pct  = 12;
        out_idle_pct = 77;
        send_beat(1'b0, 32'h1234_5678);
        configure(32'h0, 32'h0001_0000, 32'h7FFF_FFFF, 32'h0, 32'h4000_0000);
        run_sequence(1, 1'b0);
        configure(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0, 32'd4);
        run_sequence(2, 1'b0);
        configure(32'hFFFF_0000, 32'h0003_0000, 32'h0, 32'h0, 32'h0);
        run_sequence(2, 1'b0);
        configure(32'h0, 32'h0, 32'h0, 32'd5, 32'd4);
        send_beat(1'b1, 32'h0);
        send_beat(1'b0, 32'hFFFF_FFFF);
        configure(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h4000_0000, 32'h4000_0000);
        send_beat(1'b1, 32'h0);
        configure(32'h0005_0000, 32'h0005_0000, 32'h10, 32'd2, 32'd8);
        send_beat(1'b1, 32'h0);
        send_beat(1'b0, 32'h0001_0000);
        send_beat(1'b1, 32'h0);
        run_sequence(0, 1'b0);
    endtask

    task automatic test_random(input int n_items, input int in_pct, input int out_pct);
        logic [31:0] lo, hi, tol, mn;
        int          target;
        in_idle_pct  = in_pct;
        out_idle_pct = out_pct;
        target = items_sent + n_items;
        while (items_sent < target) begin
            lo = $urandom;
            hi = ($urandom_range(3) == 0) ? $urandom : lo + $urandom_range(0, 32'h0004_0000);
            if ($urandom_range(1)) {lo, hi} = {hi, lo};
            case ($urandom_range(3))
                0:       tol = 32'h0;
                1:       tol = $urandom_range(0, 256);
                2:       tol = $urandom >> 1;
                default: tol = $urandom;
            endcase
            mn = ($urandom_range(15) == 0) ? $urandom : $urandom_range(0, 64);
            configure(lo, hi, tol, mn, $urandom_range(0, 128));
            run_sequence(0, 1'b1);
        end
    endtask

    initial begin
        cycles         <= 0;
        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_addr     <= rmb_pkg::REG_LOWER;
        i_cfg_wdata    <= 32'h0;
        i_in_valid     <= 1'b0;
        i_restart      <= 1'b0;
        i_sample_value <= 32'sh0;
        i_out_ready    <= 1'b0;
        error_count  = 0;
        items_sent   = 0;
        in_idle_pct  = 0;
        out_idle_pct = 0;
        cfg_lower    = rmb_pkg::RST_LOWER;
        cfg_upper    = rmb_pkg::RST_UPPER;
        cfg_tol      = rmb_pkg::RST_TOL;
        cfg_min_int  = rmb_pkg::RST_MIN_INT;
        cfg_max_int  = rmb_pkg::RST_MAX_INT;
        run_sum      = 0;
        prev_est     = 0;
        run_start    = 0;
        level        = 0;
        n_intervals  = 2;
        point        = 0;
        phase        = PH_IDLE;
        swapped      = 1'b0;
        span         = 32'h0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(300, 12, 77);
        test_random(300, 77, 12);
        test_random(250, 0, 0);

        drain_and_settle();
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/rmb_pkg.sv
rtl/rmb_ram.sv
rtl/romberg_integrator.sv
test/tb_romberg_integrator.sv
